>>> hw/rtl/wifi_deauth_header_parser_unit_defines.svh
// Assertion macros used by the header parser checker.
`ifndef WIFI_DEAUTH_HEADER_PARSER_UNIT_DEFINES_SVH
`define WIFI_DEAUTH_HEADER_PARSER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WDHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define WDHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wdhp_pkg.sv
// Types, constants and the frame evaluation function of the header parser.
package wdhp_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 5;
    localparam int LEN_W      = POS_W + 1;
    localparam int ADDR_BYTES = 6;
    localparam int ADDR_W     = ADDR_BYTES * BYTE_W;

    // Byte positions inside the header
    localparam logic [POS_W-1:0] POS_FC_LOW  = 5'd0;
    localparam logic [POS_W-1:0] POS_FC_HIGH = 5'd1;
    localparam logic [POS_W-1:0] POS_ADDR1   = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR2   = 5'd10;
    localparam logic [POS_W-1:0] POS_ADDR3   = 5'd16;
    localparam logic [POS_W-1:0] POS_SEQ_LO  = 5'd22;
    localparam logic [POS_W-1:0] POS_SEQ_HI  = 5'd23;
    localparam logic [POS_W-1:0] POS_MAX     = 5'd31;

    // Header lengths without and with the Order bit
    localparam logic [POS_W-1:0] HDR_LEN_BASE  = 5'd24;
    localparam logic [POS_W-1:0] HDR_LEN_ORDER = 5'd28;

    // Frame control codes
    localparam logic [1:0] TYPE_MGMT        = 2'd0;
    localparam logic [3:0] SUBTYPE_DISASSOC = 4'd10;
    localparam logic [3:0] SUBTYPE_DEAUTH   = 4'd12;
    localparam int FLAG_PROTECTED_BIT = 6;
    localparam int FLAG_ORDER_BIT     = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] fc_low;
        logic [BYTE_W-1:0] fc_high;
        logic [ADDR_W-1:0] addr_one;
        logic [ADDR_W-1:0] addr_two;
        logic [ADDR_W-1:0] addr_three;
        logic [15:0]       seq_ctrl;
        logic [15:0]       reason;
    } capture_t;

    typedef struct packed {
        logic              accepted;
        logic [ADDR_W-1:0] receiver_addr;
        logic [ADDR_W-1:0] transmitter_addr;
        logic [ADDR_W-1:0] bss_id;
        logic [3:0]        subtype_code;
        logic [BYTE_W-1:0] frame_flags;
        logic [3:0]        fragment_number;
        logic [11:0]       sequence_number;
        logic [15:0]       reason_code;
        logic              reason_present;
        logic              body_truncated;
    } result_t;

    // Judge a finished frame from its captured fields and its length in bytes.
    function automatic result_t evaluate(capture_t cap, logic [LEN_W-1:0] len);
        result_t          res;
        logic [LEN_W-1:0] hdr;
        logic [1:0]       ftype;
        logic [3:0]       sub;
        logic             ok;
        res   = '0;
        hdr   = cap.fc_high[FLAG_ORDER_BIT] ? LEN_W'(HDR_LEN_ORDER) : LEN_W'(HDR_LEN_BASE);
        ftype = cap.fc_low[3:2];
        sub   = cap.fc_low[7:4];
        ok    = (len >= LEN_W'(HDR_LEN_BASE)) && (ftype == TYPE_MGMT)
                && ((sub == SUBTYPE_DISASSOC) || (sub == SUBTYPE_DEAUTH)) && (len >= hdr);
        if (ok) begin
            res.accepted         = 1'b1;
            res.receiver_addr    = cap.addr_one;
            res.transmitter_addr = cap.addr_two;
            res.bss_id           = cap.addr_three;
            res.subtype_code     = sub;
            res.frame_flags      = cap.fc_high;
            res.fragment_number  = cap.seq_ctrl[3:0];
            res.sequence_number  = cap.seq_ctrl[15:4];
            // Protected frames carry an encrypted body: report no reason
            if (!cap.fc_high[FLAG_PROTECTED_BIT]) begin
                if (len < hdr + LEN_W'(2)) begin
                    res.body_truncated = 1'b1;
                end
                else begin
                    res.reason_code    = cap.reason;
                    res.reason_present = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/wdhp_field_capture.sv
// Header field capture registers, written one byte per transaction by position.
module wdhp_field_capture
    import wdhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [POS_W-1:0]  pos,
    input  logic [BYTE_W-1:0] data_byte,
    output capture_t          cap_next
);

    capture_t         cap_reg;
    logic [POS_W-1:0] hdr_len;

    // Steer the byte into the field that owns its position
    always_comb begin
        hdr_len  = cap_reg.fc_high[FLAG_ORDER_BIT] ? HDR_LEN_ORDER : HDR_LEN_BASE;
        cap_next = cap_reg;
        if (load) begin
            if (pos == POS_FC_LOW) begin
                cap_next.fc_low = data_byte;
            end
            if (pos == POS_FC_HIGH) begin
                cap_next.fc_high = data_byte;
            end
            for (int k = 0; k < ADDR_BYTES; k++) begin
                if (pos == POS_W'(POS_ADDR1 + k)) begin
                    cap_next.addr_one[BYTE_W*k +: BYTE_W] = data_byte;
                end
                if (pos == POS_W'(POS_ADDR2 + k)) begin
                    cap_next.addr_two[BYTE_W*k +: BYTE_W] = data_byte;
                end
                if (pos == POS_W'(POS_ADDR3 + k)) begin
                    cap_next.addr_three[BYTE_W*k +: BYTE_W] = data_byte;
                end
            end
            if (pos == POS_SEQ_LO) begin
                cap_next.seq_ctrl[7:0] = data_byte;
            end
            if (pos == POS_SEQ_HI) begin
                cap_next.seq_ctrl[15:8] = data_byte;
            end
            // Reason bytes follow the header, whose length the Order bit sets
            if (pos == hdr_len) begin
                cap_next.reason[7:0] = data_byte;
            end
            else if (pos == hdr_len + POS_W'(1)) begin
                cap_next.reason[15:8] = data_byte;
            end
        end
    end

    // Hold captured fields across frames
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cap_reg <= '0;
        end
        else begin
            cap_reg <= cap_next;
        end
    end

endmodule

>>> hw/rtl/wifi_deauth_header_parser_unit.sv
// Top level: 802.11 disassociation/deauthentication header parser.
// Result path: the byte carrying frame_end is registered in the input register, then its result in the output register.
// Throughput: one byte per cycle; input stalls only while a frame end sits in the
// input register behind a result that the output side has not yet taken.
// Reset: clears the byte position, valid flags and all captured header fields.
module wifi_deauth_header_parser_unit
    import wdhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              frame_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic [47:0]       receiver_addr,
    output logic [47:0]       transmitter_addr,
    output logic [47:0]       bss_id,
    output logic [3:0]        subtype_code,
    output logic [7:0]        frame_flags,
    output logic [3:0]        fragment_number,
    output logic [11:0]       sequence_number,
    output logic [15:0]       reason_code,
    output logic              reason_present,
    output logic              body_truncated
);

    logic              in_accept;
    logic              s1_hold;
    logic              s1_load;
    logic              result_fire;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_end_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    capture_t          cap_next;

    // Hold the input register only when a frame end meets a blocked result
    assign s1_hold     = s1_valid_reg && s1_end_reg && out_valid_reg && out_stall;
    assign in_stall    = s1_hold;
    assign in_accept   = in_valid && !in_stall;
    assign s1_load     = s1_valid_reg && !s1_hold;
    assign result_fire = s1_load && s1_end_reg;

    // Advance the byte position, saturate on long frames, restart on frame end
    always_comb begin
        pos_next = pos_reg;
        if (in_accept) begin
            if (frame_end) begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else begin
            pos_reg <= pos_next;
            if (!s1_hold) begin
                s1_valid_reg <= in_accept;
            end
        end
    end

    // Register the accepted byte with its position
    always_ff @(posedge clk) begin
        if (in_accept) begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= frame_end;
            s1_pos_reg  <= pos_reg;
        end
    end

    wdhp_field_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_load),
        .pos       (s1_pos_reg),
        .data_byte (s1_byte_reg),
        .cap_next  (cap_next)
    );

    // Keep the result until the output side takes it
    assign out_valid_next = result_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (result_fire) begin
            out_reg <= evaluate(cap_next, {1'b0, s1_pos_reg} + LEN_W'(1));
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_reg.accepted;
    assign receiver_addr    = out_reg.receiver_addr;
    assign transmitter_addr = out_reg.transmitter_addr;
    assign bss_id           = out_reg.bss_id;
    assign subtype_code     = out_reg.subtype_code;
    assign frame_flags      = out_reg.frame_flags;
    assign fragment_number  = out_reg.fragment_number;
    assign sequence_number  = out_reg.sequence_number;
    assign reason_code      = out_reg.reason_code;
    assign reason_present   = out_reg.reason_present;
    assign body_truncated   = out_reg.body_truncated;

endmodule

>>> hw/rtl/wdhp_checker.sv
// Port-level checker for the header parser, bound to the top level.
`include "wifi_deauth_header_parser_unit_defines.svh"

module wdhp_checker
    import wdhp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        accepted,
    input logic [47:0] receiver_addr,
    input logic [47:0] transmitter_addr,
    input logic [47:0] bss_id,
    input logic [3:0]  subtype_code,
    input logic [7:0]  frame_flags,
    input logic [3:0]  fragment_number,
    input logic [11:0] sequence_number,
    input logic [15:0] reason_code,
    input logic        reason_present,
    input logic        body_truncated
);

    logic fields_clear;
    logic subtype_ok;
    logic reason_ok;

    // A rejected result carries all-zero fields
    assign fields_clear = accepted
                          || (receiver_addr == '0 && transmitter_addr == '0 && bss_id == '0
                              && subtype_code == '0 && frame_flags == '0
                              && fragment_number == '0 && sequence_number == '0
                              && reason_code == '0 && !reason_present && !body_truncated);

    // Accepted results name a disassociation or deauthentication subtype
    assign subtype_ok = !accepted || subtype_code == SUBTYPE_DISASSOC
                        || subtype_code == SUBTYPE_DEAUTH;

    // A present reason excludes truncation and protection
    assign reason_ok = !reason_present
                       || (!body_truncated && !frame_flags[FLAG_PROTECTED_BIT]);

    // Keep a stalled result on the port
    `WDHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // Input stalls only behind a blocked result
    `WDHP_ASSERT(a_stall_cause, !in_stall || (out_valid && out_stall), "input stalled without cause")

    // A rejected frame reports nothing else
    `WDHP_ASSERT(a_reject_clean, !out_valid || fields_clear, "rejected frame carries fields")

    // Accepted frames are disassociation or deauthentication only
    `WDHP_ASSERT(a_subtype, !out_valid || subtype_ok, "bad subtype accepted")

    // Reason flags stay consistent
    `WDHP_ASSERT(a_reason, !out_valid || reason_ok, "reason flags conflict")

endmodule

bind wifi_deauth_header_parser_unit wdhp_checker u_wdhp_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the 802.11 disassociation/deauthentication header parser.
`timescale 1ns / 100ps

module tb_top
    import wdhp_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_BYTES  = 1050;
    localparam int OUT_HOLD_LEN  = 300;
    localparam int SETTLE_CYCLES = 20;

    // Byte fill patterns for the body of a generated frame
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // Frame types other than management
    localparam logic [1:0] TYPE_CTRL = 2'd1;
    localparam logic [1:0] TYPE_DATA = 2'd2;
    localparam logic [1:0] TYPE_EXT  = 2'd3;

    // Management subtypes that must be rejected
    localparam logic [3:0] SUBTYPE_ASSOC_REQ = 4'd0;
    localparam logic [3:0] SUBTYPE_AUTH      = 4'd11;
    localparam logic [3:0] SUBTYPE_RESERVED  = 4'd15;

    localparam logic [7:0] FLAG_RETRY     = 8'h08;
    localparam logic [7:0] FLAG_PROTECTED = 8'h01 << FLAG_PROTECTED_BIT;
    localparam logic [7:0] FLAG_ORDER     = 8'h01 << FLAG_ORDER_BIT;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic [47:0] receiver_addr;
    logic [47:0] transmitter_addr;
    logic [47:0] bss_id;
    logic [3:0]  subtype_code;
    logic [7:0]  frame_flags;
    logic [3:0]  fragment_number;
    logic [11:0] sequence_number;
    logic [15:0] reason_code;
    logic        reason_present;
    logic        body_truncated;

    // Parser state as seen from the byte stream
    logic [4:0]  byte_pos_q;
    logic [7:0]  fc_low_q;
    logic [7:0]  fc_high_q;
    logic [47:0] addr_one_q;
    logic [47:0] addr_two_q;
    logic [47:0] addr_three_q;
    logic [15:0] seq_ctrl_q;
    logic [15:0] reason_q;

    result_t     frame_reports[$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    bit          sender_gaps = 1'b1;
    bit          hold_request = 1'b0;

    wifi_deauth_header_parser_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .frame_end        (frame_end),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (accepted),
        .receiver_addr    (receiver_addr),
        .transmitter_addr (transmitter_addr),
        .bss_id           (bss_id),
        .subtype_code     (subtype_code),
        .frame_flags      (frame_flags),
        .fragment_number  (fragment_number),
        .sequence_number  (sequence_number),
        .reason_code      (reason_code),
        .reason_present   (reason_present),
        .body_truncated   (body_truncated)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    // Capture one byte and, on frame end, compute the report for the frame.
    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        result_t    rep;
        int         hdr;
        int         len;
        int         pos;
        logic [3:0] sub;
        pos = byte_pos_q;
        hdr = fc_high_q[FLAG_ORDER_BIT] ? int'(HDR_LEN_ORDER) : int'(HDR_LEN_BASE);
        if (byte_pos_q == POS_FC_LOW)
            fc_low_q = b;
        else if (byte_pos_q == POS_FC_HIGH)
            fc_high_q = b;
        else if (byte_pos_q >= POS_ADDR1 && byte_pos_q < POS_ADDR2)
            addr_one_q[(byte_pos_q - POS_ADDR1) * 8 +: 8] = b;
        else if (byte_pos_q >= POS_ADDR2 && byte_pos_q < POS_ADDR3)
            addr_two_q[(byte_pos_q - POS_ADDR2) * 8 +: 8] = b;
        else if (byte_pos_q >= POS_ADDR3 && byte_pos_q < POS_SEQ_LO)
            addr_three_q[(byte_pos_q - POS_ADDR3) * 8 +: 8] = b;
        else if (byte_pos_q == POS_SEQ_LO)
            seq_ctrl_q[7:0] = b;
        else if (byte_pos_q == POS_SEQ_HI)
            seq_ctrl_q[15:8] = b;
        if (pos == hdr)
            reason_q[7:0] = b;
        else if (pos == hdr + 1)
            reason_q[15:8] = b;

        // Advance with saturation, or close the frame
        if (!last)
        begin
            if (byte_pos_q != POS_MAX)
                byte_pos_q = byte_pos_q + 5'd1;
        end
        else
        begin
            len = pos + 1;
            byte_pos_q = '0;
            rep = '0;
            sub = fc_low_q[7:4];
            hdr = fc_high_q[FLAG_ORDER_BIT] ? int'(HDR_LEN_ORDER) : int'(HDR_LEN_BASE);
            if (len >= int'(HDR_LEN_BASE) && fc_low_q[3:2] == TYPE_MGMT
                && (sub == SUBTYPE_DISASSOC || sub == SUBTYPE_DEAUTH) && len >= hdr)
            begin
                rep.accepted         = 1'b1;
                rep.receiver_addr    = addr_one_q;
                rep.transmitter_addr = addr_two_q;
                rep.bss_id           = addr_three_q;
                rep.subtype_code     = sub;
                rep.frame_flags      = fc_high_q;
                rep.fragment_number  = seq_ctrl_q[3:0];
                rep.sequence_number  = seq_ctrl_q[15:4];
                // Encrypted body: no reason reported
                if (!fc_high_q[FLAG_PROTECTED_BIT])
                begin
                    if (len < hdr + 2)
                        rep.body_truncated = 1'b1;
                    else
                    begin
                        rep.reason_code    = reason_q;
                        rep.reason_present = 1'b1;
                    end
                end
            end
            frame_reports.push_back(rep);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!sender_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte and wait for the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        frame_end <= last;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        parse_frame_byte(b, last);
    endtask

    task automatic send_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                              input int len, input int fill);
        logic [7:0] b;
        int         i;
        for (i = 0; i < len; i++)
        begin
            if (i == 0)
                b = fc0;
            else if (i == 1)
                b = fc1;
            else if (fill == FILL_ZERO)
                b = 8'h00;
            else if (fill == FILL_ONES)
                b = 8'hff;
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == len - 1);
        end
    endtask

    function automatic logic [7:0] mgmt_fc(input logic [3:0] sub);
        return {sub, TYPE_MGMT, 2'($urandom_range(0, 3))};
    endfunction

    // Mostly well-formed frames, some cut short, some noise.
    task automatic send_random_frame();
        logic [7:0] fc0;
        logic [7:0] fc1;
        int         len;
        int         fill;
        int         r;
        r    = $urandom_range(0, 99);
        fc1  = 8'($urandom_range(0, 255));
        fill = ($urandom_range(0, 19) == 0) ? int'($urandom_range(FILL_ZERO, FILL_ONES))
                                             : FILL_RANDOM;
        if (r < 75)
        begin
            fc0 = mgmt_fc($urandom_range(0, 1) ? SUBTYPE_DEAUTH : SUBTYPE_DISASSOC);
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(24, 32) : $urandom_range(33, 45);
        end
        else if (r < 90)
        begin
            fc0 = mgmt_fc($urandom_range(0, 1) ? SUBTYPE_DEAUTH : SUBTYPE_DISASSOC);
            len = $urandom_range(1, 23);
        end
        else
        begin
            fc0 = 8'($urandom_range(0, 255));
            len = $urandom_range(1, 40);
        end
        send_frame(fc0, fc1, len, fill);
    endtask

    task automatic wait_reports_drained();
        in_valid <= 1'b0;
        while (frame_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: compare each transaction with the oldest report
    initial
    begin : report_checker
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (frame_reports.size() == 0)
                begin
                    $error("result transaction with no frame pending");
                    fail_count++;
                end
                else
                begin
                    want = frame_reports.pop_front();
                    check_field("accepted", want.accepted, accepted);
                    check_field("receiver_addr", want.receiver_addr, receiver_addr);
                    check_field("transmitter_addr", want.transmitter_addr, transmitter_addr);
                    check_field("bss_id", want.bss_id, bss_id);
                    check_field("subtype_code", want.subtype_code, subtype_code);
                    check_field("frame_flags", want.frame_flags, frame_flags);
                    check_field("fragment_number", want.fragment_number, fragment_number);
                    check_field("sequence_number", want.sequence_number, sequence_number);
                    check_field("reason_code", want.reason_code, reason_code);
                    check_field("reason_present", want.reason_present, reason_present);
                    check_field("body_truncated", want.body_truncated, body_truncated);
                end
            end
        end
    end

    // Result side: random stalls, quiet stretches, and a long hold on request
    initial
    begin : stall_driver
        int  hold_left;
        int  stall_left;
        int  quiet_left;
        int  r;
        logic nxt;
        hold_left  = 0;
        stall_left = 0;
        quiet_left = 0;
        forever
        begin
            @(posedge clk);
            nxt = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = OUT_HOLD_LEN - 1;
                nxt = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1'b1;
            end
            else if (quiet_left > 0)
                quiet_left--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    quiet_left = $urandom_range(50, 200);
                else if (r < 20)
                begin
                    stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                             : $urandom_range(10, 40);
                    nxt = 1'b1;
                end
            end
            out_stall <= nxt;
        end
    end

    // Frames too short to hold a header
    task automatic test_short_frames();
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'h00, 1, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'h00, 2, FILL_RANDOM);
    endtask

    // Both accepted subtypes, rejected subtypes and the non-management types
    task automatic test_subtypes();
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'h00, 26, FILL_ZERO);
        send_frame(mgmt_fc(SUBTYPE_DISASSOC), FLAG_RETRY, 26, FILL_ONES);
        send_frame(mgmt_fc(SUBTYPE_AUTH), 8'h00, 26, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_ASSOC_REQ), 8'h00, 26, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_RESERVED), 8'h00, 26, FILL_RANDOM);
        send_frame({SUBTYPE_DEAUTH, TYPE_CTRL, 2'b00}, 8'h00, 26, FILL_RANDOM);
        send_frame({SUBTYPE_DEAUTH, TYPE_DATA, 2'b11}, 8'h00, 26, FILL_RANDOM);
        send_frame({SUBTYPE_DISASSOC, TYPE_EXT, 2'b00}, 8'h00, 26, FILL_RANDOM);
    endtask

    // Length edges around the base and the longer header
    task automatic test_header_lengths();
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'h00, 23, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'h00, 24, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'h00, 25, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DISASSOC), 8'h00, 26, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), FLAG_ORDER, 27, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), FLAG_ORDER, 28, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), FLAG_ORDER, 29, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DISASSOC), FLAG_ORDER, 30, FILL_RANDOM);
    endtask

    // Protected frames report no reason
    task automatic test_protected();
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), FLAG_PROTECTED, 26, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DISASSOC), FLAG_PROTECTED, 24, FILL_RANDOM);
    endtask

    // Byte position saturation on long frames
    task automatic test_long_frames();
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), FLAG_ORDER, 31, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DEAUTH), FLAG_ORDER, 32, FILL_RANDOM);
        send_frame(mgmt_fc(SUBTYPE_DISASSOC), 8'hff & ~FLAG_PROTECTED, 40, FILL_RANDOM);
    endtask

    // Hold the result side while frames keep coming back to back
    task automatic test_output_hold();
        int i;
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        for (i = 0; i < 10; i++)
            send_frame(mgmt_fc(SUBTYPE_DEAUTH), 8'($urandom_range(0, 255)),
                       $urandom_range(24, 30), FILL_RANDOM);
        sender_gaps = 1'b1;
        wait_reports_drained();
    endtask

    // Let every result come out between frames
    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 4; i++)
        begin
            send_random_frame();
            wait_reports_drained();
        end
    endtask

    task automatic test_random_frames();
        int stop_at;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        byte_pos_q   = '0;
        fc_low_q     = '0;
        fc_high_q    = '0;
        addr_one_q   = '0;
        addr_two_q   = '0;
        addr_three_q = '0;
        seq_ctrl_q   = '0;
        reason_q     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_subtypes();
        test_header_lengths();
        test_protected();
        test_long_frames();
        test_output_hold();
        test_drain_pause();
        test_random_frames();

        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && frame_reports.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
